// ----- sv/vbcu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vbcu_pkg;
	localparam int MAX_WIDTH = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_SAMPLES = 32;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int SW = $clog2(MAX_SAMPLES);
	localparam int AW = XW + YW + SW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_SAMPLES;
	localparam int DW = 24;

	localparam logic [2:0] REG_COLOR_MODE = 3'd0;
	localparam logic [2:0] REG_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_MIN_MATCH = 3'd2;
	localparam logic [2:0] REG_NUM_SAMPLES = 3'd3;
	localparam logic [2:0] REG_UPDATE_FACTOR = 3'd4;
	localparam logic [2:0] REG_FRAME_WIDTH = 3'd5;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;
	localparam logic [2:0] REG_NEIGHBOR_HALF = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SELF,
		ST_NBR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       color_mode;
		logic [7:0] threshold;
		logic [5:0] min_match;
		logic [5:0] num_samples;
		logic [8:0] update_factor;
		logic [6:0] frame_width;
		logic [6:0] frame_height;
		logic [1:0] neighbor_half;
	} cfg_t;

	function automatic logic [AW-1:0] store_addr(logic [XW-1:0] x, logic [YW-1:0] y,
		logic [SW-1:0] s);
		return {y, x, s};
	endfunction
endpackage
`default_nettype wire

// ----- sv/vbcu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vbcu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/vbcu_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vbcu_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [8:0]        cfg_data,
	output vbcu_pkg::cfg_t         cfg
);
	import vbcu_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mode    <= 1'b0;
			cfg_q.threshold     <= 8'd20;
			cfg_q.min_match     <= 6'd2;
			cfg_q.num_samples   <= 6'd20;
			cfg_q.update_factor <= 9'd16;
			cfg_q.frame_width   <= 7'd64;
			cfg_q.frame_height  <= 7'd64;
			cfg_q.neighbor_half <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLOR_MODE:    cfg_q.color_mode    <= cfg_data[0];
				REG_THRESHOLD:     cfg_q.threshold     <= cfg_data[7:0];
				REG_MIN_MATCH:     cfg_q.min_match     <= cfg_data[5:0];
				REG_NUM_SAMPLES:   cfg_q.num_samples   <= cfg_data[5:0];
				REG_UPDATE_FACTOR: cfg_q.update_factor <= cfg_data;
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data[6:0];
				REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data[6:0];
				REG_NEIGHBOR_HALF: cfg_q.neighbor_half <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// ----- sv/vbcu_match.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vbcu_match (
	input  wire logic             color_mode,
	input  wire logic [7:0]       threshold,
	input  wire logic [23:0]      pix,
	input  wire logic [23:0]      smp,
	output logic                  hit
);
	import vbcu_pkg::*;

	logic [7:0]  d0, d1, d2;
	logic [9:0]  l1;
	logic [11:0] t9;

	always_comb begin
		d0 = (pix[7:0] > smp[7:0]) ? pix[7:0] - smp[7:0] : smp[7:0] - pix[7:0];
		d1 = (pix[15:8] > smp[15:8]) ? pix[15:8] - smp[15:8] : smp[15:8] - pix[15:8];
		d2 = (pix[23:16] > smp[23:16]) ? pix[23:16] - smp[23:16]
			: smp[23:16] - pix[23:16];
		l1 = {2'b0, d0} + {2'b0, d1} + {2'b0, d2};
		t9 = {threshold, 3'b0} + {4'b0, threshold};
		if (!color_mode)
			hit = d0 < threshold;
		else
			hit = {1'b0, l1, 1'b0} < t9;
	end
endmodule
`default_nettype wire

// ----- sv/vibe_background_classify_update.sv -----
`timescale 1ns / 1ps
// Per-pixel background classifier with sample model update.
// Input channel (valid/stall): one request per pixel. req_type 0 classifies
// the pixel against its stored samples and, when background, may overwrite
// one own sample and one neighbor sample chosen by the draw fields.
// req_type 1 loads one sample directly.
// Output channel (valid/stall): one result per request, is_foreground and
// match_count (zero for a load).
// Samples live in one single-port-write, registered-read memory; the
// classifier reads one sample per cycle and stops early once min_match
// samples have matched; a load skips the compare. A new request is taken in
// the cycle after the result is delivered. One request is in flight at a
// time; stall holds the result register and the block takes no new request
// until the result is delivered. Reset returns configuration to defaults;
// sample memory is undefined until loaded. Configuration writes are to be
// made while the block is idle; the block itself does not enforce this.
`default_nettype none
module vibe_background_classify_update (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [8:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [5:0]        pix_x,
	input  wire logic [5:0]        pix_y,
	input  wire logic [7:0]        chan0,
	input  wire logic [7:0]        chan1,
	input  wire logic [7:0]        chan2,
	input  wire logic [15:0]       self_draw,
	input  wire logic [15:0]       self_slot_draw,
	input  wire logic [15:0]       nbr_draw,
	input  wire logic [15:0]       nbr_slot_draw,
	input  wire logic signed [2:0] nbr_dx,
	input  wire logic signed [2:0] nbr_dy,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   is_foreground,
	output logic [5:0]             match_count
);
	import vbcu_pkg::*;

	cfg_t cfg;
	vbcu_cfg u_cfg (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg);

	state_t state_q, state_d;

	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [23:0]   pix_q;
	logic          upd_self_q, upd_nbr_q;
	logic [SW-1:0] sslot_q, nslot_q;
	logic [XW-1:0] nx_q;
	logic [YW-1:0] ny_q;
	logic [5:0]    ns_q, mm_q;
	logic [5:0]    idx_q;
	logic          rd_pend_q;
	logic [5:0]    cnt_q;
	logic          fg_q;
	logic [5:0]    mcnt_q;
	logic          ov_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [23:0]   wdata, rdata;
	logic          hit;

	vbcu_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	vbcu_match u_match (
		.color_mode(cfg.color_mode), .threshold(cfg.threshold),
		.pix(pix_q), .smp(rdata), .hit
	);

	// request decode
	logic        accept;
	logic [5:0]  ns_c, mm_c;
	logic [24:0] sdp, ndp;
	logic [21:0] sslot_p, nslot_p;
	logic signed [3:0] h, dx, dy;
	logic signed [8:0] tx, ty, fw, fh;
	logic        nbr_ok, tx_ok, ty_ok;
	logic [23:0] pix_c;

	always_comb begin
		accept = in_valid && !in_stall;
		ns_c = (cfg.num_samples > 6'(MAX_SAMPLES)) ? 6'(MAX_SAMPLES) : cfg.num_samples;
		mm_c = (cfg.min_match == 6'd0) ? 6'd1 : cfg.min_match;
		pix_c = cfg.color_mode ? {chan2, chan1, chan0} : {16'b0, chan0};
		sdp = {9'b0, self_draw} * {16'b0, cfg.update_factor};
		ndp = {9'b0, nbr_draw} * {16'b0, cfg.update_factor};
		sslot_p = 22'({6'b0, self_slot_draw} * {16'b0, ns_c});
		nslot_p = 22'({6'b0, nbr_slot_draw} * {16'b0, ns_c});
		h = {2'b0, cfg.neighbor_half};
		dx = (4'(nbr_dx) > h) ? h : ((4'(nbr_dx) < -h) ? -h : 4'(nbr_dx));
		dy = (4'(nbr_dy) > h) ? h : ((4'(nbr_dy) < -h) ? -h : 4'(nbr_dy));
		fw = (cfg.frame_width == 7'd0) ? 9'sd1
			: ((cfg.frame_width > 7'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {2'b0, cfg.frame_width});
		fh = (cfg.frame_height == 7'd0) ? 9'sd1
			: ((cfg.frame_height > 7'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT)
			: {2'b0, cfg.frame_height});
		tx = $signed({3'b0, pix_x}) + 9'(dx);
		ty = $signed({3'b0, pix_y}) + 9'(dy);
		if (tx < 0 || tx >= fw)
			tx = $signed({3'b0, pix_x}) - 9'(dx);
		if (ty < 0 || ty >= fh)
			ty = $signed({3'b0, pix_y}) - 9'(dy);
		tx_ok = tx >= 0 && tx < fw;
		ty_ok = ty >= 0 && ty < fh;
		nbr_ok = tx_ok && ty_ok && !(dx == 0 && dy == 0) && ndp[24:16] == 9'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	logic stop;
	always_comb begin
		// compare the sample returned for the previous read
		stop = rd_pend_q && hit && (cnt_q + 6'd1 >= mm_q);
		state_d = state_q;
		we = 1'b0;
		waddr = store_addr(x_q, y_q, sslot_q);
		wdata = pix_q;
		raddr = store_addr(x_q, y_q, idx_q[SW-1:0]);
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_READ;
			end
			ST_READ: begin
				if (stop || (!rd_pend_q && idx_q >= ns_q) ||
					(rd_pend_q && idx_q >= ns_q))
					state_d = ST_SELF;
				if (stop || (idx_q >= ns_q && !(rd_pend_q && !stop)))
					state_d = ST_SELF;
				else if (idx_q >= ns_q)
					state_d = ST_READ;
				if (idx_q >= ns_q && rd_pend_q && !stop)
					state_d = ST_READ;
			end
			ST_SELF: begin
				we = !fg_q && upd_self_q;
				state_d = ST_NBR;
			end
			ST_NBR: begin
				we = !fg_q && upd_nbr_q;
				waddr = store_addr(nx_q, ny_q, nslot_q);
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && accept)
				rd_pend_q <= 1'b0;
			else if (state_q == ST_READ)
				rd_pend_q <= !stop && idx_q < ns_q;
			if (state_q == ST_NBR)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			x_q <= pix_x;
			y_q <= pix_y;
			pix_q <= (req_type) ? {chan2, chan1, chan0} : pix_c;
			idx_q <= 6'd0;
			cnt_q <= 6'd0;
			if (req_type) begin
				// load: write through the self path, skip the compare
				ns_q <= 6'd0;
				mm_q <= 6'd1;
				upd_self_q <= self_slot_draw < 16'(MAX_SAMPLES);
				sslot_q <= self_slot_draw[SW-1:0];
				upd_nbr_q <= 1'b0;
			end else begin
				ns_q <= ns_c;
				mm_q <= mm_c;
				upd_self_q <= sdp[24:16] == 9'd0;
				sslot_q <= sslot_p[16+SW-1:16];
				upd_nbr_q <= nbr_ok;
			end
			nslot_q <= nslot_p[16+SW-1:16];
			nx_q <= tx[XW-1:0];
			ny_q <= ty[YW-1:0];
			fg_q <= !req_type;
		end else if (state_q == ST_READ) begin
			if (rd_pend_q && hit)
				cnt_q <= cnt_q + 6'd1;
			if (!stop && idx_q < ns_q)
				idx_q <= idx_q + 6'd1;
			if (state_d == ST_SELF) begin
				if (ns_q == 6'd0 && mm_q == 6'd1 && !fg_q) begin
					fg_q <= 1'b0;
					mcnt_q <= 6'd0;
				end else begin
					fg_q <= !stop;
					mcnt_q <= cnt_q + {5'b0, rd_pend_q && hit};
				end
			end
		end
	end

	assign out_valid = ov_q;
	assign is_foreground = fg_q;
	assign match_count = mcnt_q;
endmodule
`default_nettype wire
